[src/kmp_pattern_occurrence_counter_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the KMP occurrence counter
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef KMP_PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH
`define KMP_PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH

// condition holds at every edge
`define KMP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define KMP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/kmp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmp_pkg
// Types and constants shared by the KMP occurrence counter modules.
// ---------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_PATTERN_DEF = 128;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_MAX = 32;
  localparam int MATCH_COUNT_W   = 24;
  localparam int SIZE_W          = 8;
  localparam int QUEUE_DEPTH     = 2;   // power of two

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic [1:0] REQ_END     = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic                     match_found;
    logic [MATCH_COUNT_W-1:0] match_count;
    logic [SIZE_W-1:0]        pattern_size;
    logic                     overflow_flag;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } eng_state_t;

endpackage

[src/kmp_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmp_front
// Accepts request words, decodes them into commands and holds them in a
// short queue for the matching engine.
// ---------------------------------------------------------------------------
module kmp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  kmp_pkg::req_t req,
  output logic          cmd_valid,
  output kmp_pkg::cmd_t cmd,
  input  logic          pop
);

  localparam int QD = kmp_pkg::QUEUE_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  kmp_pkg::cmd_t entry [QD];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  kmp_pkg::op_t  op_dec;
  logic          push;

  always_comb begin
    unique case (req.req_type)
      kmp_pkg::REQ_CLEAR:   op_dec = kmp_pkg::OP_CLEAR;
      kmp_pkg::REQ_PATTERN: op_dec = kmp_pkg::OP_PATTERN;
      kmp_pkg::REQ_TEXT:    op_dec = kmp_pkg::OP_TEXT;
      default:              op_dec = kmp_pkg::OP_END;
    endcase
  end

  assign req_ready = (fill != CW'(QD));
  assign push      = req_valid && req_ready;
  assign cmd_valid = (fill != '0);
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{op: op_dec, data: req.byte_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QW'(1);
      if (pop)  rd_ptr <= rd_ptr + QW'(1);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (!push && pop) fill <= fill - CW'(1);
    end
  end

endmodule

[src/kmp_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmp_engine
// Pattern store, failure table and the failure-link walker shared by
// pattern loading and text matching; drives the result register.
// ---------------------------------------------------------------------------
module kmp_engine #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = kmp_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  kmp_pkg::cmd_t cmd,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kmp_pkg::rsp_t rsp
);

  localparam int AW    = $clog2(MAX_PATTERN);
  localparam int LW    = $clog2(MAX_PATTERN + 1);
  localparam int LWX   = kmp_pkg::SIZE_W + LW;
  localparam int CWMAX = kmp_pkg::COUNT_WIDTH_MAX;

  logic [7:0]    pat_mem  [MAX_PATTERN];
  logic [AW-1:0] fail_mem [MAX_PATTERN];
  logic [7:0]    pat_rd;
  logic [AW-1:0] fail_rd;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_byte;
  logic [AW-1:0] wr_fail;

  kmp_pkg::eng_state_t state, state_next;
  logic [AW-1:0]          cur_j, cur_j_next;
  logic [7:0]             cur_byte, cur_byte_next;
  logic                   walk_text, walk_text_next;
  logic [LW-1:0]          len, len_next;
  logic [AW-1:0]          prefix, prefix_next;
  logic [AW-1:0]          match_pos, match_pos_next;
  logic [AW-1:0]          last_fail, last_fail_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic                   rsp_valid_next;
  logic                   load;
  kmp_pkg::rsp_t          res;

  logic                   mismatch;
  logic [LW-1:0]          step;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic [CWMAX-1:0]       count_wide;
  logic [LWX-1:0]         len_wide;
  logic [LWX-1:0]         len_inc_wide;
  logic                   full;
  logic                   out_free;

  assign mismatch     = (pat_rd != cur_byte);
  assign step         = LW'(cur_j) + LW'(!mismatch);
  assign count_sat    = (&count) ? count : count + COUNT_WIDTH'(1);
  assign count_wide   = CWMAX'(count);
  assign len_wide     = LWX'(len);
  assign len_inc_wide = LWX'(len) + LWX'(1);
  assign full         = (len >= LW'(MAX_PATTERN));
  assign out_free     = !rsp_valid || rsp_ready;
  assign wr_addr      = len[AW-1:0];

  // both tables: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[wr_addr]  <= wr_byte;
      fail_mem[wr_addr] <= wr_fail;
    end
    pat_rd  <= pat_mem[rd_addr];
    fail_rd <= fail_mem[rd_addr - AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kmp_pkg::ST_IDLE;
      len       <= '0;
      prefix    <= '0;
      match_pos <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      prefix    <= prefix_next;
      match_pos <= match_pos_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_j     <= cur_j_next;
    cur_byte  <= cur_byte_next;
    walk_text <= walk_text_next;
    last_fail <= last_fail_next;
    if (load) rsp <= res;
  end

  always_comb begin
    state_next     = state;
    cur_j_next     = cur_j;
    cur_byte_next  = cur_byte;
    walk_text_next = walk_text;
    len_next       = len;
    prefix_next    = prefix;
    match_pos_next = match_pos;
    last_fail_next = last_fail;
    count_next     = count;
    rd_addr        = cur_j;
    wr_en          = 1'b0;
    wr_byte        = cur_byte;
    wr_fail        = '0;
    pop            = 1'b0;
    load           = 1'b0;
    res            = '0;
    res.match_count  = count_wide[kmp_pkg::MATCH_COUNT_W-1:0];
    res.pattern_size = len_wide[kmp_pkg::SIZE_W-1:0];

    unique case (state)
      kmp_pkg::ST_IDLE: begin
        // only take a command once the result register is sure to be free
        if (cmd_valid && out_free) begin
          pop           = 1'b1;
          cur_byte_next = cmd.data;
          unique case (cmd.op)
            kmp_pkg::OP_CLEAR: begin
              load             = 1'b1;
              len_next         = '0;
              prefix_next      = '0;
              match_pos_next   = '0;
              count_next       = '0;
              res.match_count  = '0;
              res.pattern_size = '0;
            end
            kmp_pkg::OP_PATTERN: begin
              if (full) begin
                load              = 1'b1;
                res.overflow_flag = 1'b1;
              end else if (len == '0) begin
                load             = 1'b1;
                wr_en            = 1'b1;
                wr_byte          = cmd.data;
                wr_fail          = '0;
                prefix_next      = '0;
                last_fail_next   = '0;
                len_next         = LW'(1);
                match_pos_next   = '0;
                res.pattern_size = len_inc_wide[kmp_pkg::SIZE_W-1:0];
              end else begin
                rd_addr        = prefix;
                cur_j_next     = prefix;
                walk_text_next = 1'b0;
                state_next     = kmp_pkg::ST_WALK;
              end
            end
            kmp_pkg::OP_TEXT: begin
              if (len == '0) begin
                load = 1'b1;
              end else begin
                rd_addr        = match_pos;
                cur_j_next     = match_pos;
                walk_text_next = 1'b1;
                state_next     = kmp_pkg::ST_WALK;
              end
            end
            kmp_pkg::OP_END: begin
              load           = 1'b1;
              match_pos_next = '0;
              count_next     = '0;
            end
            default: ;
          endcase
        end
      end

      kmp_pkg::ST_WALK: begin
        if (cur_j != '0 && mismatch) begin
          // follow one failure link; read data for it arrives next cycle
          cur_j_next = fail_rd;
          rd_addr    = fail_rd;
        end else begin
          load       = 1'b1;
          state_next = kmp_pkg::ST_IDLE;
          if (walk_text) begin
            if (step >= len) begin
              res.match_found = 1'b1;
              count_next      = count_sat;
              match_pos_next  = last_fail;
              res.match_count = CWMAX'(count_sat) >> 0 == '0 ? '0 :
                                kmp_pkg::MATCH_COUNT_W'(CWMAX'(count_sat));
            end else begin
              match_pos_next = step[AW-1:0];
            end
          end else begin
            wr_en            = 1'b1;
            wr_byte          = cur_byte;
            wr_fail          = step[AW-1:0];
            prefix_next      = step[AW-1:0];
            last_fail_next   = step[AW-1:0];
            len_next         = len + LW'(1);
            match_pos_next   = '0;
            res.pattern_size = len_inc_wide[kmp_pkg::SIZE_W-1:0];
          end
        end
      end

      default: state_next = kmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (load)           rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else                rsp_valid_next = rsp_valid;
  end

endmodule

[src/kmp_pattern_occurrence_counter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmp_pattern_occurrence_counter_core
// Knuth-Morris-Pratt occurrence counter: loads a byte pattern, builds its
// failure table as it arrives and counts overlapping matches in text.
// ---------------------------------------------------------------------------
// Every request word yields one response word. Requests pass through a
// two-word queue into the engine, which keeps the pattern and failure table
// in two single-port-read memories (no clearing pass after reset). Clear,
// end of text, a dropped pattern byte, the first pattern byte and a text
// byte on an empty pattern are answered from the idle state; any other
// pattern or text byte goes on to the walk state, which follows failure
// links one per cycle via the read port; over a stream these total at most
// the number of bytes. The engine starts a request only when the response
// register is empty or is being read in that cycle, so a waiting response
// stalls the engine while the queue still takes up to two more requests.
`include "kmp_pattern_occurrence_counter_core_macros.svh"

module kmp_pattern_occurrence_counter_core #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = kmp_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  kmp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kmp_pkg::rsp_t rsp
);

  logic          cmd_valid;
  kmp_pkg::cmd_t cmd;
  logic          pop;
  logic          ovf_out;

  kmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  kmp_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign ovf_out = rsp_valid && rsp.overflow_flag;

  `KMP_ASSERT_IMPL(a_pop_has_cmd, pop, cmd_valid, "pop from empty queue")
  `KMP_ASSERT_IMPL(a_pop_out_free, pop, !rsp_valid || rsp_ready, "pop while result stalled")
  `KMP_ASSERT_IMPL(a_ovf_full, ovf_out, rsp.pattern_size == 8'(MAX_PATTERN), "drop below capacity")
  `KMP_ASSERT_ALWAYS(a_ovf_no_match, !(ovf_out && rsp.match_found), "drop with match")

endmodule

[bench/tb_kmp_pattern_occurrence_counter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_kmp_pattern_occurrence_counter_core
// Self-checking bench for the KMP occurrence counter. A scoreboard class keeps
// its own copy of the pattern, the border table and the counters, and works
// out the response word for every request word that the block accepts. Each
// response is checked field by field against the oldest prediction. Stimulus
// is a short directed sequence, then randomized match sessions (clear,
// pattern, text, end of text), patterns changed mid-stream, full-store
// overflow runs and random noise words. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module tb_kmp_pattern_occurrence_counter_core;

  localparam int MAX_PAT      = kmp_pkg::MAX_PATTERN_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 35;

  class kmp_scoreboard;
    logic [7:0]                        pat_mem [MAX_PAT];
    logic [kmp_pkg::SIZE_W-1:0]        border_mem [MAX_PAT];
    logic [kmp_pkg::SIZE_W-1:0]        pat_len;
    logic [kmp_pkg::SIZE_W-1:0]        prefix_len;
    logic [kmp_pkg::SIZE_W-1:0]        match_pos;
    logic [kmp_pkg::MATCH_COUNT_W-1:0] occ_count;
    kmp_pkg::rsp_t                     responses_due [$];
    int                                errors;
    int                                checked;
    int                                hits;
    int                                drops;

    function new();
      foreach (pat_mem[i]) begin
        pat_mem[i]    = '0;
        border_mem[i] = '0;
      end
      pat_len    = '0;
      prefix_len = '0;
      match_pos  = '0;
      occ_count  = '0;
      errors     = 0;
      checked    = 0;
      hits       = 0;
      drops      = 0;
    endfunction

    // extend the pattern and its border table by one byte
    function void append_byte(logic [7:0] b);
      logic [kmp_pkg::SIZE_W-1:0] k;
      pat_mem[pat_len] = b;
      if (pat_len == 0) begin
        prefix_len    = '0;
        border_mem[0] = '0;
      end else begin
        k = prefix_len;
        while (k > 0 && pat_mem[k] != b) k = border_mem[k - 1];
        if (pat_mem[k] == b) k++;
        prefix_len          = k;
        border_mem[pat_len] = k;
      end
      pat_len++;
      match_pos = '0;
    endfunction

    function logic advance_text(logic [7:0] b);
      logic [kmp_pkg::SIZE_W-1:0] j;
      logic                       hit;
      j   = match_pos;
      hit = 1'b0;
      while (j > 0 && pat_mem[j] != b) j = border_mem[j - 1];
      if (pat_mem[j] == b) j++;
      if (j >= pat_len) begin
        hit = 1'b1;
        if (occ_count != '1) occ_count++;
        // fall back so overlapping occurrences are counted
        j = border_mem[pat_len - 1];
      end
      match_pos = j;
      return hit;
    endfunction

    function kmp_pkg::rsp_t compute_response(kmp_pkg::req_t w);
      kmp_pkg::rsp_t r;
      r = '0;
      case (w.req_type)
        kmp_pkg::REQ_CLEAR: begin
          pat_len    = '0;
          prefix_len = '0;
          match_pos  = '0;
          occ_count  = '0;
        end
        kmp_pkg::REQ_PATTERN: begin
          if (pat_len >= MAX_PAT) r.overflow_flag = 1'b1;
          else append_byte(w.byte_value);
          r.match_count = occ_count;
        end
        kmp_pkg::REQ_TEXT: begin
          if (pat_len > 0) r.match_found = advance_text(w.byte_value);
          r.match_count = occ_count;
        end
        default: begin
          r.match_count = occ_count;
          match_pos     = '0;
          occ_count     = '0;
        end
      endcase
      r.pattern_size = pat_len;
      return r;
    endfunction

    function void note_input(kmp_pkg::req_t w);
      responses_due.push_back(compute_response(w));
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check(kmp_pkg::rsp_t got);
      kmp_pkg::rsp_t want;
      if (responses_due.size() == 0) begin
        report_mismatch($sformatf("response word %h with none pending", got));
        return;
      end
      want = responses_due.pop_front();
      checked++;
      if (want.match_found) hits++;
      if (want.overflow_flag) drops++;
      if (got.match_found !== want.match_found)
        report_mismatch($sformatf("word %0d match_found %b, want %b",
                                  checked, got.match_found, want.match_found));
      if (got.match_count !== want.match_count)
        report_mismatch($sformatf("word %0d match_count %0d, want %0d",
                                  checked, got.match_count, want.match_count));
      if (got.pattern_size !== want.pattern_size)
        report_mismatch($sformatf("word %0d pattern_size %0d, want %0d",
                                  checked, got.pattern_size, want.pattern_size));
      if (got.overflow_flag !== want.overflow_flag)
        report_mismatch($sformatf("word %0d overflow_flag %b, want %b",
                                  checked, got.overflow_flag, want.overflow_flag));
    endtask
  endclass

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  kmp_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  kmp_pkg::rsp_t rsp;

  kmp_scoreboard sb = new();

  bit idle_on     = 1'b1;
  int hold_calls  = 0;
  int words_sent  = 0;
  int cycle_count = 0;

  kmp_pattern_occurrence_counter_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // response side: random stalls, plus one long hold-off when asked
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_calls) begin
        hold_seen = hold_calls;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check(rsp);
  end

  task automatic send_word(logic [1:0] kind, logic [7:0] value);
    kmp_pkg::req_t w;
    w.req_type   = kind;
    w.byte_value = value;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    sb.note_input(w);
    words_sent++;
  endtask

  // clear, load a pattern over a small alphabet, then one or two text passes
  task automatic match_session(int plen, int tlen, int nsym);
    logic [7:0] alpha [4];
    logic [7:0] pat [$];
    int         i;
    int         passes;
    for (i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(255));
    send_word(kmp_pkg::REQ_CLEAR, 8'($urandom_range(255)));
    for (i = 0; i < plen; i++) begin
      pat.push_back(alpha[$urandom_range(nsym - 1)]);
      send_word(kmp_pkg::REQ_PATTERN, pat[i]);
    end
    // end of text keeps the pattern, so a second pass reuses the table
    passes = ($urandom_range(2) == 0) ? 2 : 1;
    repeat (passes) begin
      i = 0;
      while (i < tlen) begin
        if ($urandom_range(3) == 0) begin
          foreach (pat[k]) send_word(kmp_pkg::REQ_TEXT, pat[k]);
          i += plen;
        end else begin
          send_word(kmp_pkg::REQ_TEXT, alpha[$urandom_range(nsym - 1)]);
          i++;
        end
      end
      send_word(kmp_pkg::REQ_END, 8'($urandom_range(255)));
    end
  endtask

  // pattern byte arriving in the middle of text
  task automatic mid_stream_pattern();
    logic [7:0] b;
    int         i;
    b = 8'($urandom_range(255));
    for (i = 0; i < 4; i++) send_word(kmp_pkg::REQ_TEXT, i[0] ? b : ~b);
    send_word(kmp_pkg::REQ_PATTERN, b);
    for (i = 0; i < 6; i++) send_word(kmp_pkg::REQ_TEXT, $urandom_range(1) ? b : ~b);
  endtask

  task automatic noise_words(int n);
    repeat (n) send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  initial begin
    int  base;
    int  r;
    int  long_runs;
    bit  hold_done;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    long_runs = 0;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pattern, overlapping hits, restart on a new pattern byte
    send_word(kmp_pkg::REQ_CLEAR,   8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_END,     8'h00);
    send_word(kmp_pkg::REQ_PATTERN, 8'h00);
    send_word(kmp_pkg::REQ_PATTERN, 8'hff);
    send_word(kmp_pkg::REQ_PATTERN, 8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_PATTERN, 8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_TEXT,    8'hff);
    send_word(kmp_pkg::REQ_END,     8'hff);
    send_word(kmp_pkg::REQ_TEXT,    8'h00);
    send_word(kmp_pkg::REQ_CLEAR,   8'h00);

    base = words_sent;
    while (words_sent < base + RANDOM_ITEMS) begin
      if (!hold_done && words_sent > base + 300) begin
        hold_calls <= hold_calls + 1;
        hold_done = 1'b1;
      end
      idle_on <= !(words_sent >= base + 1000 && words_sent < base + 1400);
      r = $urandom_range(99);
      if (r < 55) begin
        match_session(1 + $urandom_range(5), 10 + $urandom_range(30),
                      1 + $urandom_range(2));
      end else if (r < 65) begin
        mid_stream_pattern();
      end else if (r < 80) begin
        noise_words(3 + $urandom_range(9));
      end else if (r < 85 && long_runs < 5) begin
        // fill the store and push past it
        long_runs++;
        match_session(MAX_PAT + 1 + $urandom_range(2), 140 + $urandom_range(40),
                      1 + $urandom_range(1));
      end else begin
        match_session(7 + $urandom_range(9), 30 + $urandom_range(40),
                      2 + $urandom_range(2));
      end
    end
    req_valid <= 1'b0;

    while (sb.responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d response words: %0d occurrences, %0d dropped pattern bytes",
             sb.checked, sb.hits, sb.drops);
    $display("%0d overflow runs, one long response hold-off, %0d mismatches",
             long_runs, sb.errors);
    if (sb.errors == 0 && sb.responses_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[kmp_pattern_occurrence_counter_core.f]
+incdir+src
src/kmp_pkg.sv
src/kmp_front.sv
src/kmp_engine.sv
src/kmp_pattern_occurrence_counter_core.sv
bench/tb_kmp_pattern_occurrence_counter_core.sv
